// File: hdl/buddy_block_allocator_core_macros.svh
// Assertion macros shared by the buddy block allocator sources.
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/bba_pkg.sv
// Types, codes and constants of the buddy block allocator.
package bba_pkg;
    localparam int LEAF_COUNT_DEF  = 256;
    localparam int MIN_BLOCK_BYTES = 4096;
    localparam int MIN_SHIFT       = $clog2(MIN_BLOCK_BYTES);
    localparam int NODE_IDX_MAX_W  = 17;
    localparam int ADDR_W          = 40;
    localparam int SIZE_W          = 32;
    localparam int BSIZE_W         = 21;
    localparam logic [ADDR_W-1:0] BASE_RESET = 40'h0000600000;

    typedef logic [1:0] t_node;
    localparam t_node NODE_EMPTY = 2'd0;
    localparam t_node NODE_SPLIT = 2'd1;
    localparam t_node NODE_FULL  = 2'd2;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_FREE  = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR = 3'd3;
    localparam logic [2:0] ST_NO_USED  = 3'd4;

    typedef struct packed {
        logic                      we;
        logic                      re;
        logic [NODE_IDX_MAX_W-1:0] waddr;
        logic [NODE_IDX_MAX_W-1:0] raddr;
        t_node                     wdata;
    } t_ram_req;
endpackage

// File: hdl/buddy_block_allocator_core.sv
// Buddy block allocator top level: request sequencer around the node memory.
//
// channel  direction  handshake            words
// request  in         start, busy          i_req_type, i_req_size, i_req_address
// result   out        o_done strobe        o_status, o_block_address, o_block_size
// config   in         i_cfg_we             i_cfg_wdata (base address)
//
// Node memory reads are registered, so each node read has a read state and a check state.
// Allocate: a size loop doubles the block until it covers the request, then a search visits
// nodes down to the needed level and rewrites each parent it passes back through.
// Free and query: climb level by level from the leaf to the used node; free then clears it
// and merges buddies level by level up to the root, query walks down to the leaf level.
// After reset a clearing pass writes every node empty while busy is high.
// One result per request, given on o_done for one cycle; the receiver cannot stall.
`include "buddy_block_allocator_core_macros.svh"
module buddy_block_allocator_core #(
    parameter int LEAF_COUNT = bba_pkg::LEAF_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_req_type,
    input  logic [bba_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [bba_pkg::ADDR_W-1:0]   i_req_address,
    output logic                         o_done,
    output logic [2:0]                   o_status,
    output logic [bba_pkg::ADDR_W-1:0]   o_block_address,
    output logic [bba_pkg::BSIZE_W-1:0]  o_block_size,
    input  logic                         i_cfg_we,
    input  logic [bba_pkg::ADDR_W-1:0]   i_cfg_wdata
);
    import bba_pkg::*;

    localparam int D  = $clog2(LEAF_COUNT);
    localparam int LW = D + 1;
    localparam int DW = $clog2(D + 1);
    localparam longint TOTAL = longint'(LEAF_COUNT) * longint'(MIN_BLOCK_BYTES);
    localparam int TW = $clog2(TOTAL) + 1;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SIZE  = 4'd2;
    localparam logic [3:0] S_V_RD  = 4'd3;
    localparam logic [3:0] S_V_CHK = 4'd4;
    localparam logic [3:0] S_RET   = 4'd5;
    localparam logic [3:0] S_A_RL  = 4'd6;
    localparam logic [3:0] S_A_RR  = 4'd7;
    localparam logic [3:0] S_A_CMP = 4'd8;
    localparam logic [3:0] S_U_RD  = 4'd9;
    localparam logic [3:0] S_U_CHK = 4'd10;
    localparam logic [3:0] S_FREE  = 4'd11;
    localparam logic [3:0] S_M_RA  = 4'd12;
    localparam logic [3:0] S_M_RB  = 4'd13;
    localparam logic [3:0] S_M_CMP = 4'd14;
    localparam logic [3:0] S_Q     = 4'd15;

    logic [3:0]         r_state, n_state;
    logic [LW-1:0]      r_idx, n_idx;
    logic [LW-1:0]      r_hit, n_hit;
    logic [DW-1:0]      r_dep, n_dep;
    logic [DW-1:0]      r_need, n_need;
    logic [DW-1:0]      r_order, n_order;
    logic [TW-1:0]      r_blk, n_blk;
    logic [SIZE_W-1:0]  r_size, n_size;
    logic [1:0]         r_type, n_type;
    logic               r_ok, n_ok;
    t_node              r_left, n_left;
    logic [ADDR_W-1:0]  r_base;
    logic               r_done, n_done;
    logic [2:0]         r_status, n_status;
    logic [ADDR_W-1:0]  r_baddr, n_baddr;
    logic [BSIZE_W-1:0] r_bsize, n_bsize;

    t_ram_req           ram_req;
    t_node              rdata;
    logic [ADDR_W:0]    rel_addr;
    logic               addr_ok;
    logic [LW-1:0]      hit_leaf;
    logic [ADDR_W-1:0]  hit_off;

    bba_node_ram #(.LEAF_COUNT(LEAF_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    // Address range check and leaf lookup for free and query.
    assign rel_addr = {1'b0, i_req_address} - {1'b0, r_base};
    assign addr_ok  = !rel_addr[ADDR_W] && (rel_addr < (ADDR_W+1)'(TOTAL));

    // Block offset of the allocated node from its leftmost leaf.
    assign hit_leaf = LW'(r_hit << (DW'(D) - r_need)) - LW'(LEAF_COUNT);
    assign hit_off  = ADDR_W'(hit_leaf[D-1:0]) << MIN_SHIFT;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_hit    = r_hit;
        n_dep    = r_dep;
        n_need   = r_need;
        n_order  = r_order;
        n_blk    = r_blk;
        n_size   = r_size;
        n_type   = r_type;
        n_ok     = r_ok;
        n_left   = r_left;
        n_done   = 1'b0;
        n_status = r_status;
        n_baddr  = r_baddr;
        n_bsize  = r_bsize;
        ram_req  = '0;
        case (r_state)
            S_CLR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = NODE_IDX_MAX_W'(r_idx);
                ram_req.wdata = NODE_EMPTY;
                n_idx = r_idx + LW'(1);
                if (&r_idx) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_type   = i_req_type;
                    n_size   = i_req_size;
                    n_status = ST_OK;
                    n_baddr  = '0;
                    n_bsize  = '0;
                    case (i_req_type) inside
                        REQ_ALLOC: begin
                            if (i_req_size == '0 || 64'(i_req_size) > 64'(TOTAL)) begin
                                n_done   = 1'b1;
                                n_status = ST_BAD_SIZE;
                            end else begin
                                n_blk   = TW'(MIN_BLOCK_BYTES);
                                n_order = '0;
                                n_state = S_SIZE;
                            end
                        end
                        REQ_FREE, REQ_QUERY: begin
                            if (!addr_ok) begin
                                n_done   = 1'b1;
                                n_status = ST_BAD_ADDR;
                            end else begin
                                n_idx   = {1'b1, rel_addr[MIN_SHIFT +: D]};
                                n_state = S_U_RD;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = ST_BAD_SIZE;
                        end
                    endcase
                end
            end
            S_SIZE: begin
                if (64'(r_size) > 64'(r_blk)) begin
                    n_blk   = r_blk << 1;
                    n_order = r_order + DW'(1);
                end else begin
                    n_need  = DW'(D) - r_order;
                    n_idx   = LW'(1);
                    n_dep   = '0;
                    n_ok    = 1'b0;
                    n_state = S_V_RD;
                end
            end
            S_V_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = NODE_IDX_MAX_W'(r_idx);
                n_state = S_V_CHK;
            end
            S_V_CHK: begin
                if (rdata == NODE_FULL) begin
                    n_ok    = 1'b0;
                    n_state = S_RET;
                end else if (r_dep == r_need) begin
                    if (rdata == NODE_SPLIT) begin
                        n_ok = 1'b0;
                    end else begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = NODE_IDX_MAX_W'(r_idx);
                        ram_req.wdata = NODE_FULL;
                        n_ok  = 1'b1;
                        n_hit = r_idx;
                    end
                    n_state = S_RET;
                end else begin
                    n_idx   = r_idx << 1;
                    n_dep   = r_dep + DW'(1);
                    n_state = S_V_RD;
                end
            end
            S_RET: begin
                // Return from the visit of r_idx: finish at the root, try the right buddy after a
                // failed left child, otherwise rewrite the parent from its two children.
                if (r_idx == LW'(1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_ok) begin
                        n_baddr = r_base + hit_off;
                    end else begin
                        n_status = ST_NO_FREE;
                    end
                end else if (!r_ok && !r_idx[0]) begin
                    n_idx   = r_idx + LW'(1);
                    n_state = S_V_RD;
                end else begin
                    n_idx   = r_idx >> 1;
                    n_dep   = r_dep - DW'(1);
                    n_state = S_A_RL;
                end
            end
            S_A_RL: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = NODE_IDX_MAX_W'({r_idx[LW-2:0], 1'b0});
                n_state = S_A_RR;
            end
            S_A_RR: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = NODE_IDX_MAX_W'({r_idx[LW-2:0], 1'b1});
                n_left  = rdata;
                n_state = S_A_CMP;
            end
            S_A_CMP: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = NODE_IDX_MAX_W'(r_idx);
                ram_req.wdata = (r_left == NODE_FULL && rdata == NODE_FULL) ?
                                NODE_FULL : NODE_SPLIT;
                n_state = S_RET;
            end
            S_U_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = NODE_IDX_MAX_W'(r_idx);
                n_state = S_U_CHK;
            end
            S_U_CHK: begin
                if (rdata == NODE_FULL) begin
                    n_order = '0;
                    n_state = (r_type == REQ_FREE) ? S_FREE : S_Q;
                end else if (r_idx == LW'(1)) begin
                    n_done   = 1'b1;
                    n_status = ST_NO_USED;
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = r_idx >> 1;
                    n_state = S_U_RD;
                end
            end
            S_FREE: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = NODE_IDX_MAX_W'(r_idx);
                ram_req.wdata = NODE_EMPTY;
                if (r_idx == LW'(1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_M_RA;
                end
            end
            S_M_RA: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = NODE_IDX_MAX_W'(r_idx);
                n_state = S_M_RB;
            end
            S_M_RB: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = NODE_IDX_MAX_W'(r_idx ^ LW'(1));
                n_left  = rdata;
                n_state = S_M_CMP;
            end
            S_M_CMP: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = NODE_IDX_MAX_W'(r_idx >> 1);
                ram_req.wdata = (r_left == NODE_EMPTY && rdata == NODE_EMPTY) ?
                                NODE_EMPTY : NODE_SPLIT;
                n_idx = r_idx >> 1;
                if ((r_idx >> 1) == LW'(1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_M_RA;
                end
            end
            S_Q: begin
                if (!r_idx[LW-1]) begin
                    n_idx   = r_idx << 1;
                    n_order = r_order + DW'(1);
                end else begin
                    n_bsize = BSIZE_W'(64'(MIN_BLOCK_BYTES) << r_order);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
            r_done  <= 1'b0;
            r_base  <= BASE_RESET;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit    <= n_hit;
        r_dep    <= n_dep;
        r_need   <= n_need;
        r_order  <= n_order;
        r_blk    <= n_blk;
        r_size   <= n_size;
        r_type   <= n_type;
        r_ok     <= n_ok;
        r_left   <= n_left;
        r_status <= n_status;
        r_baddr  <= n_baddr;
        r_bsize  <= n_bsize;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_block_address = r_baddr;
    assign o_block_size    = r_bsize;

    `BBA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy || o_done, "accepted word did not start work")
    `BBA_ASSERT_IMP(a_no_rw_overlap, i_clk, i_rst_n, ram_req.we, !ram_req.re, "node memory read and written in one cycle")
    `BBA_ASSERT_IMP(a_zero_fields, i_clk, i_rst_n, o_done && o_status != ST_OK, o_block_address == '0 && o_block_size == '0, "failed result carries nonzero fields")
endmodule

// File: hdl/bba_node_ram.sv
// Node state memory: one write port and one registered read port.
module bba_node_ram #(
    parameter int LEAF_COUNT = bba_pkg::LEAF_COUNT_DEF
) (
    input  logic              i_clk,
    input  bba_pkg::t_ram_req i_req,
    output bba_pkg::t_node    o_rdata
);
    import bba_pkg::*;

    localparam int AW = $clog2(LEAF_COUNT) + 1;

    t_node r_mem [2*LEAF_COUNT];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: tb/tb.sv
// Self-checking testbench for the buddy block allocator core.
module tb;
    import bba_pkg::*;

    localparam int LEAVES = 256;
    localparam int NODES = 2 * LEAVES;
    localparam int DEPTH = 8;
    localparam longint REGION = longint'(LEAVES) * MIN_BLOCK_BYTES;
    localparam int LIMIT_CYCLES = 8000000;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [2:0]         status;
        logic [ADDR_W-1:0]  baddr;
        logic [BSIZE_W-1:0] bsize;
    } t_word;

    // Tracks the expected tree and compares words coming out of the core.
    class alloc_scoreboard;
        t_node tree[NODES];
        logic [ADDR_W-1:0] base;
        t_word pending[$];
        int mismatches;

        function void clear();
            foreach (tree[i]) tree[i] = NODE_EMPTY;
            base = BASE_RESET;
            mismatches = 0;
        endfunction

        function bit search(int idx, int lvl, int want, longint off, longint bsz,
                            ref longint res);
            bit ok;
            if (tree[idx] == NODE_FULL) return 0;
            if (lvl == want) begin
                if (tree[idx] == NODE_SPLIT) return 0;
                tree[idx] = NODE_FULL;
                res = off;
                return 1;
            end
            ok = search(2 * idx, lvl + 1, want, off, bsz / 2, res);
            if (!ok) ok = search(2 * idx + 1, lvl + 1, want, off + bsz / 2, bsz / 2, res);
            if (tree[2 * idx] == NODE_FULL && tree[2 * idx + 1] == NODE_FULL)
                tree[idx] = NODE_FULL;
            else
                tree[idx] = NODE_SPLIT;
            return ok;
        endfunction

        function void note_request(logic [1:0] kind, logic [SIZE_W-1:0] sz,
                                   logic [ADDR_W-1:0] addr);
            t_word w;
            longint res, blk, off;
            int order, node, i;
            w = '0;
            if (kind == REQ_ALLOC) begin
                if (sz == 0 || longint'(sz) > REGION) begin
                    w.status = ST_BAD_SIZE;
                end else begin
                    order = 0;
                    blk = MIN_BLOCK_BYTES;
                    while (longint'(sz) > blk) begin
                        order++;
                        blk = blk * 2;
                    end
                    res = 0;
                    if (search(1, 0, DEPTH - order, 0, REGION, res))
                        w.baddr = base + res[ADDR_W-1:0];
                    else
                        w.status = ST_NO_FREE;
                end
            end else if (kind == REQ_FREE || kind == REQ_QUERY) begin
                off = longint'(addr) - longint'(base);
                if (addr < base || off >= REGION) begin
                    w.status = ST_BAD_ADDR;
                end else begin
                    node = int'(off / MIN_BLOCK_BYTES) + LEAVES;
                    while (node != 0 && tree[node] != NODE_FULL) node = node / 2;
                    if (node == 0) begin
                        w.status = ST_NO_USED;
                    end else if (kind == REQ_FREE) begin
                        tree[node] = NODE_EMPTY;
                        i = node;
                        while (i > 1) begin
                            if (tree[i] == NODE_EMPTY && tree[i ^ 1] == NODE_EMPTY)
                                tree[i / 2] = NODE_EMPTY;
                            else
                                tree[i / 2] = NODE_SPLIT;
                            i = i / 2;
                        end
                    end else begin
                        blk = MIN_BLOCK_BYTES;
                        i = node;
                        while (i < LEAVES) begin
                            i = i * 2;
                            blk = blk * 2;
                        end
                        w.bsize = blk[BSIZE_W-1:0];
                    end
                end
            end else begin
                w.status = ST_BAD_SIZE;
            end
            pending.push_back(w);
        endfunction

        function void check_word(t_word got);
            t_word want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected word: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.baddr !== want.baddr
                    || got.bsize !== want.bsize) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: exp st=%0d addr=%h size=%0d, got st=%0d addr=%h size=%0d",
                             want.status, want.baddr, want.bsize,
                             got.status, got.baddr, got.bsize);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, start, busy, o_done, i_cfg_we;
    logic [1:0] i_req_type;
    logic [SIZE_W-1:0] i_req_size;
    logic [ADDR_W-1:0] i_req_address, o_block_address, i_cfg_wdata;
    logic [2:0] o_status;
    logic [BSIZE_W-1:0] o_block_size;

    alloc_scoreboard sb;
    int cycle_count;
    logic [ADDR_W-1:0] handed_out[$];

    buddy_block_allocator_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_req_size(i_req_size),
        .i_req_address(i_req_address), .o_done(o_done), .o_status(o_status),
        .o_block_address(o_block_address), .o_block_size(o_block_size),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done) begin
            sb.check_word('{o_status, o_block_address, o_block_size});
            if (o_status == ST_OK && o_block_address != 0)
                handed_out.push_back(o_block_address);
        end
        if (i_rst_n && start && !busy) sb.note_request(i_req_type, i_req_size, i_req_address);
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Simulation FAILED");
        $finish;
    end

    // Holds one request on the ports until the core takes it.
    task automatic send(logic [1:0] kind, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] addr);
        start <= 1;
        i_req_type <= kind;
        i_req_size <= sz;
        i_req_address <= addr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_base(logic [ADDR_W-1:0] value);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.base = value;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(1, 1048576);
            2: return 0;
            default: return $urandom_range(1, 32768);
        endcase
    endfunction

    task automatic random_phase(int count);
        int done_items, burst, k;
        logic [1:0] kind;
        logic [ADDR_W-1:0] addr;
        done_items = 0;
        while (done_items < count) begin
            burst = $urandom_range(1, 12);
            for (k = 0; k < burst && done_items < count; k++) begin
                kind = 2'($urandom_range(0, 3));
                if (kind != REQ_ALLOC && handed_out.size() != 0 && $urandom_range(0, 4) != 0)
                    addr = handed_out[$urandom_range(0, handed_out.size() - 1)]
                           + $urandom_range(0, 3 * MIN_BLOCK_BYTES);
                else if ($urandom_range(0, 2) == 0)
                    addr = ADDR_W'({$urandom(), $urandom()});
                else
                    addr = sb.base + $urandom_range(0, 1100000);
                if (kind == REQ_FREE && handed_out.size() > 40) void'(handed_out.pop_front());
                send(kind, pick_size(), addr);
                done_items++;
            end
            if ($urandom_range(0, 2) != 0) begin
                start <= 0;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        cycle_count = 0;
        i_rst_n = 0;
        start = 0;
        i_req_type = REQ_ALLOC;
        i_req_size = 0;
        i_req_address = 0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: bad sizes, whole region, smallest blocks, frees and queries.
        send(REQ_ALLOC, 0, 0);
        send(REQ_ALLOC, 32'hFFFF_FFFF, 0);
        send(REQ_ALLOC, 1048577, 0);
        send(REQ_ALLOC, 1048576, 0);
        send(REQ_ALLOC, 1, 0);
        send(REQ_QUERY, 0, 40'h600000);
        send(REQ_FREE, 0, 40'h600000 + 12345);
        send(REQ_FREE, 0, 40'h600000);
        send(REQ_ALLOC, 1, 0);
        send(REQ_ALLOC, 4097, 0);
        send(REQ_ALLOC, 524288, 0);
        send(REQ_QUERY, 0, 40'h600000 + 8192);
        send(REQ_QUERY, 0, 40'h5FFFFF);
        send(REQ_QUERY, 0, 40'h700000);
        send(REQ_FREE, 0, 0);
        send(REQ_UNKNOWN, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        send(REQ_FREE, 0, 40'h6FFFFF);
        send(REQ_FREE, 0, 40'h600000 + 4096);
        drain();

        set_base(40'hFF_FFFF_F000);
        send(REQ_ALLOC, 8192, 0);
        send(REQ_QUERY, 0, 40'hFF_FFFF_FFFF);
        set_base(40'h0);
        send(REQ_QUERY, 0, 0);
        handed_out.delete();
        random_phase(200);
        set_base(ADDR_W'({$urandom(), $urandom()}));
        handed_out.delete();
        random_phase(190);
        set_base(BASE_RESET);
        handed_out.delete();
        random_phase(190);
        drain();

        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
